[design/yuv420_box_downscale_rgb565_assert.svh]
// Assertion helpers for the downscaler; clk and rst must be in scope.
`ifndef YUV420_BOX_DOWNSCALE_RGB565_ASSERT_SVH
`define YUV420_BOX_DOWNSCALE_RGB565_ASSERT_SVH

// Same-cycle implication.
`define Y420DS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define Y420DS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/y420ds_pkg.sv]
package y420ds_pkg;

  localparam int OUT_WIDTH  = 160;
  localparam int OUT_HEIGHT = 120;

  localparam int COL_W  = 8;
  localparam int ROW_W  = 7;
  localparam int POS_W  = 11;
  localparam int BAND_W = 3;

  localparam int LUMA_SUM_W   = 16;
  localparam int CHROMA_SUM_W = 14;
  localparam int ACC_W        = 26;

  typedef logic [1:0] ratio_t;
  localparam ratio_t RATIO_4  = 2'd0;
  localparam ratio_t RATIO_8  = 2'd1;
  localparam ratio_t RATIO_16 = 2'd2;

  // last chroma column position of a row, per ratio
  localparam logic [POS_W-1:0] POS_LAST_4  = POS_W'(OUT_WIDTH * 2 - 1);
  localparam logic [POS_W-1:0] POS_LAST_8  = POS_W'(OUT_WIDTH * 4 - 1);
  localparam logic [POS_W-1:0] POS_LAST_16 = POS_W'(OUT_WIDTH * 8 - 1);

  typedef logic signed [ACC_W-1:0] acc_t;

  localparam acc_t COEF_RV = ACC_W'(91881);
  localparam acc_t COEF_GU = ACC_W'(22554);
  localparam acc_t COEF_GV = ACC_W'(46802);
  localparam acc_t COEF_BU = ACC_W'(116130);

  typedef struct packed {
    logic [LUMA_SUM_W-1:0]   luma;
    logic [CHROMA_SUM_W-1:0] u;
    logic [CHROMA_SUM_W-1:0] v;
  } line_t;

  localparam int LINE_W = $bits(line_t);

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } pix_meta_t;

  typedef struct packed {
    logic [7:0] y;
    logic [7:0] u;
    logic [7:0] v;
    pix_meta_t  meta;
  } avg_t;

  function automatic logic [7:0] clamp_q16(acc_t a);
    logic [ACC_W-17:0] w;
    w = a[ACC_W-1:16];
    if (a < 0) begin
      return 8'd0;
    end else if (w > (ACC_W-16)'(255)) begin
      return 8'hFF;
    end else begin
      return w[7:0];
    end
  endfunction

  function automatic logic [15:0] pack_rgb565(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

[design/y420ds_ram.sv]
module y420ds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read-first: a same-cycle write is not seen
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/y420ds_conv.sv]
module y420ds_conv
  import y420ds_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  avg_t      avg,
  output logic      out_valid,
  input  logic      out_stall,
  output logic [15:0] pixel,
  output pix_meta_t meta
);

  logic      a_valid;
  avg_t      a;
  logic      p_valid;
  pix_meta_t p_meta;
  acc_t      p_yq, p_rv, p_gu, p_gv, p_bu;

  logic out_free, p_free, a_free;
  logic signed [9:0] du, dv;
  acc_t r_acc, g_acc, b_acc;

  assign out_free = !out_valid || !out_stall;
  assign p_free   = !p_valid || out_free;
  assign a_free   = !a_valid || p_free;
  assign in_stall = !a_free;

  assign du = $signed({2'b00, a.u}) - 10'sd128;
  assign dv = $signed({2'b00, a.v}) - 10'sd128;

  assign r_acc = p_yq + p_rv;
  assign g_acc = p_yq - p_gu - p_gv;
  assign b_acc = p_yq + p_bu;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_free) begin
        a_valid <= in_valid;
      end
      if (p_free) begin
        p_valid <= a_valid;
      end
      if (out_free) begin
        out_valid <= p_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_free) begin
      a <= avg;
    end
    // products in Q16
    if (a_valid && p_free) begin
      p_meta <= a.meta;
      p_yq   <= acc_t'({a.y, 16'h0000});
      p_rv   <= COEF_RV * acc_t'(dv);
      p_gu   <= COEF_GU * acc_t'(du);
      p_gv   <= COEF_GV * acc_t'(dv);
      p_bu   <= COEF_BU * acc_t'(du);
    end
    if (p_valid && out_free) begin
      meta  <= p_meta;
      pixel <= pack_rgb565(clamp_q16(r_acc), clamp_q16(g_acc), clamp_q16(b_acc));
    end
  end

endmodule

[design/yuv420_box_downscale_rgb565.sv]
// Box-filter downscaler from a YUV420 stream to an RGB565 preview.
// Input channel (in_valid / in_stall): one chroma site per transfer in raster
// order, carrying its 2x2 luma quad and the co-sited U and V samples.
// Output channel (out_valid / out_stall): one RGB565 pixel with its preview
// row and column, and last_of_frame on the final pixel of the frame.
// Config channel (cfg_valid / cfg_ready / ratio_mode): selects the ratio
// 4, 8 or 16 and restarts the frame; write it only while the block is idle.
// Throughput: one input transfer per cycle while in_stall is low, set by the
// read-add-write on the column line store (one RAM, write-to-read forwarding).
// A pixel shows on out_valid once the block-completing transfer has passed
// accumulation and the converter's input, multiply and clamp-and-pack stages.
// Reset clears the ratio to 4 and all position counters; the line store is
// not cleared, since the first site of each block overwrites its entry.
// When the receiver stalls, the output stages fill and then in_stall rises
// only when a block-completing site cannot move on; other sites keep flowing.
`include "yuv420_box_downscale_rgb565_assert.svh"

module yuv420_box_downscale_rgb565
  import y420ds_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  luma_top_left,
  input  logic [7:0]  luma_top_right,
  input  logic [7:0]  luma_bottom_left,
  input  logic [7:0]  luma_bottom_right,
  input  logic [7:0]  chroma_u,
  input  logic [7:0]  chroma_v,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] pixel_rgb565,
  output logic [6:0]  out_row,
  output logic [7:0]  out_col,
  output logic        last_of_frame,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  ratio_mode
);

  ratio_t             ratio;
  logic [POS_W-1:0]   pos;
  logic [BAND_W-1:0]  band;
  logic [ROW_W-1:0]   prow;

  logic [BAND_W-1:0]  sub_mask;
  logic [BAND_W-1:0]  sub;
  logic [COL_W-1:0]   col;
  logic [POS_W-1:0]   pos_last;
  logic               accept, cfg_write;

  logic               s1_valid;
  logic [9:0]         s1_quad;
  logic [7:0]         s1_u, s1_v;
  logic [COL_W-1:0]   s1_col;
  logic               s1_first, s1_emit, s1_last;
  logic [ROW_W-1:0]   s1_row;
  ratio_t             s1_ratio;
  logic               s1_fire;

  logic               fwd_valid;
  logic [COL_W-1:0]   fwd_col;
  line_t              fwd_data;

  line_t              rd_line, base, sum;
  logic [LINE_W-1:0]  rdata;
  avg_t               avg;
  logic               conv_stall;
  pix_meta_t          out_meta;

  // position decode for the current ratio; code 3 acts as 16
  always_comb begin
    unique case (ratio)
      RATIO_4: begin
        sub_mask = 3'b001;
        col      = pos[8:1];
        pos_last = POS_LAST_4;
      end
      RATIO_8: begin
        sub_mask = 3'b011;
        col      = pos[9:2];
        pos_last = POS_LAST_8;
      end
      default: begin
        sub_mask = 3'b111;
        col      = pos[10:3];
        pos_last = POS_LAST_16;
      end
    endcase
  end

  assign sub       = pos[BAND_W-1:0] & sub_mask;
  assign cfg_ready = !s1_valid;
  assign cfg_write = cfg_valid && cfg_ready;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio <= RATIO_4;
      pos   <= '0;
      band  <= '0;
      prow  <= '0;
    end else if (cfg_write) begin
      ratio <= ratio_mode;
      pos   <= '0;
      band  <= '0;
      prow  <= '0;
    end else if (accept) begin
      if (pos == pos_last) begin
        pos <= '0;
        if (band == sub_mask) begin
          band <= '0;
          prow <= (prow == ROW_W'(OUT_HEIGHT - 1)) ? '0 : prow + 1'b1;
        end else begin
          band <= band + 1'b1;
        end
      end else begin
        pos <= pos + 1'b1;
      end
    end
  end

  // accumulate stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_quad  <= 10'(luma_top_left) + 10'(luma_top_right)
                + 10'(luma_bottom_left) + 10'(luma_bottom_right);
      s1_u     <= chroma_u;
      s1_v     <= chroma_v;
      s1_col   <= col;
      s1_row   <= prow;
      s1_ratio <= ratio;
      s1_first <= (band == '0) && (sub == '0);
      s1_emit  <= (band == sub_mask) && (sub == sub_mask);
      s1_last  <= (prow == ROW_W'(OUT_HEIGHT - 1)) && (col == COL_W'(OUT_WIDTH - 1));
    end
  end

  y420ds_ram #(
    .WIDTH (LINE_W),
    .DEPTH (OUT_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_col),
    .wdata (sum),
    .re    (accept),
    .raddr (col),
    .rdata (rdata)
  );

  assign rd_line = rdata;

  // forward the previous write, which the read in the same cycle missed
  always_comb begin
    if (s1_first) begin
      base = '0;
    end else if (fwd_valid && (fwd_col == s1_col)) begin
      base = fwd_data;
    end else begin
      base = rd_line;
    end
    sum.luma = base.luma + LUMA_SUM_W'(s1_quad);
    sum.u    = base.u + CHROMA_SUM_W'(s1_u);
    sum.v    = base.v + CHROMA_SUM_W'(s1_v);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (s1_fire) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      fwd_col  <= s1_col;
      fwd_data <= sum;
    end
  end

  always_comb begin
    case (s1_ratio)
      RATIO_4: begin
        avg.y = sum.luma[11:4];
        avg.u = sum.u[9:2];
        avg.v = sum.v[9:2];
      end
      RATIO_8: begin
        avg.y = sum.luma[13:6];
        avg.u = sum.u[11:4];
        avg.v = sum.v[11:4];
      end
      default: begin
        avg.y = sum.luma[15:8];
        avg.u = sum.u[13:6];
        avg.v = sum.v[13:6];
      end
    endcase
    avg.meta.row  = s1_row;
    avg.meta.col  = s1_col;
    avg.meta.last = s1_last;
  end

  // sites that finish no block drop out after the line store write
  assign s1_fire  = s1_valid && (!s1_emit || !conv_stall);
  assign in_stall = s1_valid && !s1_fire;

  y420ds_conv u_conv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid && s1_emit),
    .in_stall  (conv_stall),
    .avg       (avg),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pixel     (pixel_rgb565),
    .meta      (out_meta)
  );

  assign out_row       = out_meta.row;
  assign out_col       = out_meta.col;
  assign last_of_frame = out_meta.last;

  `Y420DS_ASSERT_IMP(a_last_at_corner, out_valid && last_of_frame, (out_row == ROW_W'(OUT_HEIGHT - 1)) && (out_col == COL_W'(OUT_WIDTH - 1)), "last_of_frame away from the frame corner")
  `Y420DS_ASSERT_IMP(a_band_in_range, 1'b1, band <= sub_mask, "band row past the block height")
  `Y420DS_ASSERT_NEXT(a_cfg_restart, cfg_write, (pos == '0) && (band == '0) && (prow == '0), "config write did not restart the frame")
  `Y420DS_ASSERT_IMP(a_stall_cause, in_stall, s1_valid && s1_emit && conv_stall, "input stalled without a held block result")

endmodule
